>>> src/cubcal_pkg.sv
// Shared types and constants for the cubic calibration core.
// Holds widths, register indexes, sequencer states and the structs between modules.
// No dependencies.
package cubcal_pkg;

  localparam int RAW_W     = 16;
  localparam int VOLT_W    = 16;
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 3;

  // Serial multiplier: 48-bit signed multiplicand, 32-bit signed multiplier.
  localparam int MCAND_W = 48;
  localparam int MPLR_W  = 32;
  localparam int STEP_W  = $clog2(MPLR_W);
  localparam int PROD_W  = MCAND_W + 1 + MPLR_W;

  // v^2 needs 32 bits, v^3 needs 46 bits.
  localparam int V2_W = 32;
  localparam int V3_W = 48;

  // Exact sum of the three terms, offset and baseline stays below 2^42.
  localparam int SUM_W = 44;

  // Binary point positions of the three products.
  localparam int T3_SHIFT = 36;
  localparam int T2_SHIFT = 24;
  localparam int T1_SHIFT = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUBIC  = 3'd0,
    REG_SQUARE = 3'd1,
    REG_LINEAR = 3'd2,
    REG_OFFSET = 3'd3,
    REG_FLOOR  = 3'd4,
    REG_SCALED = 3'd5,
    REG_RAW    = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_CU,
    ST_T3,
    ST_T2,
    ST_T1,
    ST_SAT,
    ST_FLR
  } seq_state_t;

  // Whether the idle sequencer is free or holds a finished result.
  typedef enum logic {
    PH_WORK,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] cubic_coeff;
    logic signed [DATA_W-1:0] square_coeff;
    logic signed [DATA_W-1:0] linear_coeff;
    logic signed [DATA_W-1:0] offset_term;
    logic signed [DATA_W-1:0] floor_value;
    logic                     scaled_enable;
    logic                     raw_enable;
  } cfg_t;

  typedef struct packed {
    logic                      start;
    logic signed [MCAND_W-1:0] mcand;
    logic [MPLR_W-1:0]         mplr;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] scaled_value;
    logic                     scaled_valid;
    logic [RAW_W-1:0]         raw_value;
    logic                     raw_valid;
    logic                     floor_hit;
  } res_t;

endpackage

>>> src/cubcal_sermul.sv
// Bit-serial signed multiplier, one multiplier bit per cycle, LSB first.
// Depends on cubcal_pkg for widths and the request/response structs.
module cubcal_sermul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cubcal_pkg::mul_req_t req_i,
  output cubcal_pkg::mul_rsp_t rsp_o
);
  import cubcal_pkg::*;

  logic signed [MCAND_W-1:0] mcand_r;
  logic [MPLR_W-1:0]         mplr_r;
  logic signed [MCAND_W:0]   acc_r;
  logic [MPLR_W-1:0]         lo_r;
  logic [STEP_W-1:0]         cnt_r;
  logic                      busy_r;
  logic                      done_r;

  logic signed [MCAND_W:0]   mcand_ext;
  logic signed [MCAND_W:0]   sum;
  logic                      last;

  always_comb begin
    mcand_ext = {mcand_r[MCAND_W-1], mcand_r};
    last      = (cnt_r == STEP_W'(MPLR_W - 1));
    // the top multiplier bit carries negative weight
    if (!mplr_r[0]) begin
      sum = acc_r;
    end else if (last) begin
      sum = acc_r - mcand_ext;
    end else begin
      sum = acc_r + mcand_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_i.start) begin
      mcand_r <= req_i.mcand;
      mplr_r  <= req_i.mplr;
      acc_r   <= '0;
    end else if (busy_r) begin
      acc_r  <= sum >>> 1;
      lo_r   <= {sum[0], lo_r[MPLR_W-1:1]};
      mplr_r <= mplr_r >> 1;
    end
  end

  assign rsp_o.done = done_r;
  assign rsp_o.prod = {acc_r, lo_r};

endmodule

>>> src/cubcal_seq.sv
// Sequencer for one sample: powers of v, three products, exact sum, saturation,
// floor check and baseline update. Drives the shared serial multiplier.
// Depends on cubcal_pkg.
module cubcal_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start_i,
  input  logic [cubcal_pkg::RAW_W-1:0]   raw_i,
  input  logic signed [cubcal_pkg::VOLT_W-1:0] volts_i,
  input  cubcal_pkg::cfg_t               cfg_i,
  input  logic                           take_i,
  output logic                           idle_o,
  output logic                           done_o,
  output cubcal_pkg::res_t               res_o,
  output cubcal_pkg::mul_req_t           mul_req_o,
  input  cubcal_pkg::mul_rsp_t           mul_rsp_i
);
  import cubcal_pkg::*;

  seq_state_t state_r, state_nxt;
  phase_t     phase_r, phase_nxt;

  logic signed [VOLT_W-1:0] v_r, v_nxt;
  logic signed [V2_W-1:0]   v2_r, v2_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [DATA_W-1:0] base_r, base_nxt;
  logic signed [DATA_W-1:0] res_r, res_nxt;
  logic                     hit_r, hit_nxt;
  logic                     sen_r, sen_nxt;
  logic                     ren_r, ren_nxt;
  logic [RAW_W-1:0]         raw_r, raw_nxt;

  logic signed [DATA_W+1:0] base_sum;
  logic                     sum_fits;
  logic                     base_fits;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    v_nxt     = v_r;
    v2_nxt    = v2_r;
    sum_nxt   = sum_r;
    base_nxt  = base_r;
    res_nxt   = res_r;
    hit_nxt   = hit_r;
    sen_nxt   = sen_r;
    ren_nxt   = ren_r;
    raw_nxt   = raw_r;

    mul_req_o.start = 1'b0;
    mul_req_o.mcand = {{(MCAND_W-VOLT_W){v_r[VOLT_W-1]}}, v_r};
    mul_req_o.mplr  = {{(MPLR_W-VOLT_W){v_r[VOLT_W-1]}}, v_r};

    sum_fits  = (sum_r[SUM_W-1:DATA_W-1] == {(SUM_W-DATA_W+1){sum_r[DATA_W-1]}});
    base_sum  = {{2{base_r[DATA_W-1]}}, base_r}
              + {{2{cfg_i.floor_value[DATA_W-1]}}, cfg_i.floor_value}
              - {{2{res_r[DATA_W-1]}}, res_r};
    base_fits = (base_sum[DATA_W+1:DATA_W-1] == {3{base_sum[DATA_W-1]}});

    unique case (state_r)
      ST_IDLE: begin
        if (phase_r == PH_DONE) begin
          // hold the result until the output register takes it
          if (take_i) begin
            phase_nxt = PH_WORK;
          end
        end else if (start_i) begin
          v_nxt   = volts_i;
          sen_nxt = cfg_i.scaled_enable;
          ren_nxt = cfg_i.raw_enable;
          raw_nxt = cfg_i.raw_enable ? raw_i : '0;
          hit_nxt = 1'b0;
          res_nxt = '0;
          sum_nxt = SUM_W'(cfg_i.offset_term) + SUM_W'(base_r);
          if (cfg_i.scaled_enable) begin
            mul_req_o.start = 1'b1;
            mul_req_o.mcand = {{(MCAND_W-VOLT_W){volts_i[VOLT_W-1]}}, volts_i};
            mul_req_o.mplr  = {{(MPLR_W-VOLT_W){volts_i[VOLT_W-1]}}, volts_i};
            state_nxt = ST_SQ;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
      end
      ST_SQ: begin
        if (mul_rsp_i.done) begin
          v2_nxt          = mul_rsp_i.prod[V2_W-1:0];
          mul_req_o.start = 1'b1;
          mul_req_o.mcand = {{(MCAND_W-V2_W){mul_rsp_i.prod[V2_W-1]}},
                             mul_rsp_i.prod[V2_W-1:0]};
          state_nxt       = ST_CU;
        end
      end
      ST_CU: begin
        if (mul_rsp_i.done) begin
          mul_req_o.start = 1'b1;
          mul_req_o.mcand = mul_rsp_i.prod[V3_W-1:0];
          mul_req_o.mplr  = cfg_i.cubic_coeff;
          state_nxt       = ST_T3;
        end
      end
      ST_T3: begin
        if (mul_rsp_i.done) begin
          sum_nxt = sum_r + $signed(mul_rsp_i.prod[T3_SHIFT+SUM_W-1:T3_SHIFT]);
          mul_req_o.start = 1'b1;
          mul_req_o.mcand = {{(MCAND_W-V2_W){v2_r[V2_W-1]}}, v2_r};
          mul_req_o.mplr  = cfg_i.square_coeff;
          state_nxt       = ST_T2;
        end
      end
      ST_T2: begin
        if (mul_rsp_i.done) begin
          sum_nxt = sum_r + $signed(mul_rsp_i.prod[T2_SHIFT+SUM_W-1:T2_SHIFT]);
          mul_req_o.start = 1'b1;
          mul_req_o.mplr  = cfg_i.linear_coeff;
          state_nxt       = ST_T1;
        end
      end
      ST_T1: begin
        if (mul_rsp_i.done) begin
          sum_nxt   = sum_r + $signed(mul_rsp_i.prod[T1_SHIFT+SUM_W-1:T1_SHIFT]);
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        if (sum_fits) begin
          res_nxt = sum_r[DATA_W-1:0];
        end else if (sum_r[SUM_W-1]) begin
          res_nxt = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
          res_nxt = {1'b0, {(DATA_W-1){1'b1}}};
        end
        state_nxt = ST_FLR;
      end
      ST_FLR: begin
        // raise the baseline by the shortfall and emit the floor itself
        if (res_r < cfg_i.floor_value) begin
          if (base_fits) begin
            base_nxt = base_sum[DATA_W-1:0];
          end else if (base_sum[DATA_W+1]) begin
            base_nxt = {1'b1, {(DATA_W-1){1'b0}}};
          end else begin
            base_nxt = {1'b0, {(DATA_W-1){1'b1}}};
          end
          res_nxt = cfg_i.floor_value;
          hit_nxt = 1'b1;
        end
        state_nxt = ST_IDLE;
        phase_nxt = PH_DONE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_WORK;
      base_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      base_r  <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    v2_r  <= v2_nxt;
    sum_r <= sum_nxt;
    res_r <= res_nxt;
    hit_r <= hit_nxt;
    sen_r <= sen_nxt;
    ren_r <= ren_nxt;
    raw_r <= raw_nxt;
  end

  assign idle_o = (state_r == ST_IDLE) && (phase_r == PH_WORK);
  assign done_o = (state_r == ST_IDLE) && (phase_r == PH_DONE);

  assign res_o.scaled_value = res_r;
  assign res_o.scaled_valid = sen_r;
  assign res_o.raw_value    = raw_r;
  assign res_o.raw_valid    = ren_r;
  assign res_o.floor_hit    = hit_r;

endmodule

>>> src/cubic_calibration_with_floor_baseline_core.sv
// Cubic sensor calibration with a self-raising floor baseline, top level.
// Scaled path: five passes through the shared bit-serial multiplier (v^2, v^3 and
// three terms), one multiplier bit per cycle; skipped when scaled_enable is clear.
// The input stalls until the previous result has entered the output register.
// Reset (rst_n low, synchronous): registers take their reset values, baseline clears,
// the output register empties. Depends on cubcal_pkg, cubcal_sermul, cubcal_seq.
module cubic_calibration_with_floor_baseline_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [cubcal_pkg::RAW_W-1:0]         in_raw_sample,
  input  logic signed [cubcal_pkg::VOLT_W-1:0] in_volts_in,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [cubcal_pkg::DATA_W-1:0] out_scaled_value,
  output logic                                 out_scaled_valid,
  output logic [cubcal_pkg::RAW_W-1:0]         out_raw_value,
  output logic                                 out_raw_valid,
  output logic                                 out_floor_hit,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cubcal_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cubcal_pkg::DATA_W-1:0]        cfg_data
);
  import cubcal_pkg::*;

  cfg_t     cfg_r;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  res_t     seq_res;
  res_t     out_res_r;
  logic     out_valid_r;

  logic     seq_idle;
  logic     seq_done;
  logic     in_fire;
  logic     take;

  // Configuration registers. The port never stalls; indexes past the last register
  // are dropped. Writes must come only while the core is idle, which is not enforced.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cubic_coeff   <= '0;
      cfg_r.square_coeff  <= '0;
      cfg_r.linear_coeff  <= 32'sd65536;
      cfg_r.offset_term   <= '0;
      cfg_r.floor_value   <= {1'b1, {(DATA_W-1){1'b0}}};
      cfg_r.scaled_enable <= 1'b1;
      cfg_r.raw_enable    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CUBIC:  cfg_r.cubic_coeff   <= cfg_data;
        REG_SQUARE: cfg_r.square_coeff  <= cfg_data;
        REG_LINEAR: cfg_r.linear_coeff  <= cfg_data;
        REG_OFFSET: cfg_r.offset_term   <= cfg_data;
        REG_FLOOR:  cfg_r.floor_value   <= cfg_data;
        REG_SCALED: cfg_r.scaled_enable <= cfg_data[0];
        REG_RAW:    cfg_r.raw_enable    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // One sample in flight: stall the input until the sequencer is back to idle.
  assign in_stall = !seq_idle;
  assign in_fire  = in_valid && !in_stall;

  // Move a finished result into the output register when it is empty or
  // being drained this cycle.
  assign take = seq_done && (!out_valid_r || !out_stall);

  cubcal_sermul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  cubcal_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (in_fire),
    .raw_i     (in_raw_sample),
    .volts_i   (in_volts_in),
    .cfg_i     (cfg_r),
    .take_i    (take),
    .idle_o    (seq_idle),
    .done_o    (seq_done),
    .res_o     (seq_res),
    .mul_req_o (mul_req),
    .mul_rsp_i (mul_rsp)
  );

  // Output register: hold while stalled, load a new beat, drop valid once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res_r <= seq_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_scaled_value = out_res_r.scaled_value;
  assign out_scaled_valid = out_res_r.scaled_valid;
  assign out_raw_value    = out_res_r.raw_value;
  assign out_raw_valid    = out_res_r.raw_valid;
  assign out_floor_hit    = out_res_r.floor_hit;

endmodule

>>> src/cubcal_chk.sv
// Port-level checker for the cubic calibration core, bound to the top level.
// Depends on cubcal_pkg for port widths.
module cubcal_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [cubcal_pkg::DATA_W-1:0] out_scaled_value,
  input logic                                 out_scaled_valid,
  input logic [cubcal_pkg::RAW_W-1:0]         out_raw_value,
  input logic                                 out_raw_valid,
  input logic                                 out_floor_hit
);

  // a sample in work blocks the next beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && !in_stall |=> in_stall)
    else $error("input accepted while previous sample still in work");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_scaled_value)
      && $stable(out_floor_hit))
    else $error("stalled result beat changed");

  // disabled scaled path gives a zero value and no floor hit
  a_scaled_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_scaled_valid |-> out_scaled_value == '0 && !out_floor_hit)
    else $error("scaled fields set while scaled path disabled");

  // disabled raw path gives a zero code
  a_raw_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_raw_valid |-> out_raw_value == '0)
    else $error("raw code set while raw path disabled");

  // reset empties the output and frees the input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("core not idle after reset");

endmodule

bind cubic_calibration_with_floor_baseline_core cubcal_chk u_cubcal_chk (.*);

>>> tb/cubcal_checker.sv
// Scoreboard for the cubic calibration core: watches the register, sample and result
// channels, predicts each result beat and compares it field by field.
// Depends on cubcal_pkg.
module cubcal_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [cubcal_pkg::RAW_W-1:0]         in_raw_sample,
  input  logic signed [cubcal_pkg::VOLT_W-1:0] in_volts_in,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [cubcal_pkg::DATA_W-1:0] out_scaled_value,
  input  logic                                 out_scaled_valid,
  input  logic [cubcal_pkg::RAW_W-1:0]         out_raw_value,
  input  logic                                 out_raw_valid,
  input  logic                                 out_floor_hit,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [cubcal_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cubcal_pkg::DATA_W-1:0]        cfg_data,
  output int                                   errors,
  output int                                   pending,
  output int                                   floor_hits,
  output logic signed [cubcal_pkg::DATA_W-1:0] baseline
);
  timeunit 1ns;
  timeprecision 1ps;
  import cubcal_pkg::*;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  localparam cfg_t CFG_RESET = '{
    cubic_coeff:   '0,
    square_coeff:  '0,
    linear_coeff:  32'sd65536,
    offset_term:   '0,
    floor_value:   32'sh8000_0000,
    scaled_enable: 1'b1,
    raw_enable:    1'b0
  };

  cfg_t                     regs = CFG_RESET;
  logic signed [DATA_W-1:0] base_acc = '0;
  res_t                     due_q[$];
  int                       err_count = 0;
  int                       hit_count = 0;

  assign errors     = err_count;
  assign floor_hits = hit_count;
  assign baseline   = base_acc;

  function automatic logic signed [DATA_W-1:0] clamp32(input longint x);
    if (x > SAT_HI) x = SAT_HI;
    if (x < SAT_LO) x = SAT_LO;
    return x[DATA_W-1:0];
  endfunction

  // Polynomial in wide signed arithmetic; an arithmetic shift is a floor divide.
  function automatic res_t calibrate(input logic [RAW_W-1:0] raw,
                                     input logic signed [VOLT_W-1:0] volts);
    logic signed [95:0]       v, v2, v3, c3, c2, c1;
    longint                   total;
    logic signed [DATA_W-1:0] level;
    res_t                     r;
    r = '0;
    if (regs.scaled_enable) begin
      v  = volts;
      v2 = v * v;
      v3 = v2 * v;
      c3 = $signed(regs.cubic_coeff);
      c2 = $signed(regs.square_coeff);
      c1 = $signed(regs.linear_coeff);
      total = longint'((c3 * v3) >>> T3_SHIFT) + longint'((c2 * v2) >>> T2_SHIFT)
            + longint'((c1 * v) >>> T1_SHIFT) + longint'($signed(regs.offset_term))
            + longint'(base_acc);
      level = clamp32(total);
      if (level < $signed(regs.floor_value)) begin
        // raise the baseline by the shortfall, emit the floor itself
        base_acc = clamp32(longint'(base_acc) + longint'($signed(regs.floor_value))
                           - longint'(level));
        level       = regs.floor_value;
        r.floor_hit = 1'b1;
        hit_count++;
      end
      r.scaled_value = level;
      r.scaled_valid = 1'b1;
    end
    if (regs.raw_enable) begin
      r.raw_value = raw;
      r.raw_valid = 1'b1;
    end
    return r;
  endfunction

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t seen;
    res_t want;
    if (!rst_n) begin
      regs     = CFG_RESET;
      base_acc = '0;
      due_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CUBIC:  regs.cubic_coeff   = cfg_data;
          REG_SQUARE: regs.square_coeff  = cfg_data;
          REG_LINEAR: regs.linear_coeff  = cfg_data;
          REG_OFFSET: regs.offset_term   = cfg_data;
          REG_FLOOR:  regs.floor_value   = cfg_data;
          REG_SCALED: regs.scaled_enable = cfg_data[0];
          REG_RAW:    regs.raw_enable    = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        due_q.push_back(calibrate(in_raw_sample, in_volts_in));
      if (out_valid && !out_stall) begin
        seen = '{out_scaled_value, out_scaled_valid, out_raw_value, out_raw_valid,
                 out_floor_hit};
        if (due_q.size() == 0) begin
          err_count++;
          $display("%0t: result beat with nothing expected, expected none, got %p",
                   $time, seen);
        end else begin
          want = due_q.pop_front();
          check_field("scaled_value", want.scaled_value, seen.scaled_value);
          check_field("scaled_valid", want.scaled_valid, seen.scaled_valid);
          check_field("raw_value", want.raw_value, seen.raw_value);
          check_field("raw_valid", want.raw_valid, seen.raw_valid);
          check_field("floor_hit", want.floor_hit, seen.floor_hit);
        end
      end
    end
    pending <= due_q.size();
  end

endmodule

>>> tb/tb_cubic_calibration_with_floor_baseline_core.sv
// Top of the cubic calibration testbench: clock, reset, register programming and
// sample stimulus, with the verdict. Depends on cubcal_pkg, cubcal_checker and the core.
module tb_cubic_calibration_with_floor_baseline_core;
  timeunit 1ns;
  timeprecision 1ps;
  import cubcal_pkg::*;

  localparam int                   CYCLE_LIMIT     = 1_000_000;
  localparam int                   TAIL_CYCLES     = 200;
  localparam int                   RAND_PHASES     = 12;
  localparam int                   ITEMS_PER_PHASE = 50;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED      = 3'd7;  // no register here
  localparam logic [DATA_W-1:0]    Q_MAX           = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0]    Q_MIN           = 32'h8000_0000;
  localparam longint               SAT_HI          = 64'sd2147483647;
  localparam longint               SAT_LO          = -64'sd2147483648;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [RAW_W-1:0]         in_raw_sample = '0;
  logic signed [VOLT_W-1:0] in_volts_in = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_scaled_value;
  logic                     out_scaled_valid;
  logic [RAW_W-1:0]         out_raw_value;
  logic                     out_raw_valid;
  logic                     out_floor_hit;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data = '0;

  int                       errors, pending, floor_hits;
  logic signed [DATA_W-1:0] baseline;
  int                       cycle_count = 0;
  int                       samples = 0;
  int                       settings = 0;
  bit                       quiet = 1'b0;   // set for the last phase: no idling anywhere

  always #1ns clk = ~clk;

  cubic_calibration_with_floor_baseline_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_raw_sample    (in_raw_sample),
    .in_volts_in      (in_volts_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_scaled_value (out_scaled_value),
    .out_scaled_valid (out_scaled_valid),
    .out_raw_value    (out_raw_value),
    .out_raw_valid    (out_raw_valid),
    .out_floor_hit    (out_floor_hit),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  cubcal_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_raw_sample    (in_raw_sample),
    .in_volts_in      (in_volts_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_scaled_value (out_scaled_value),
    .out_scaled_valid (out_scaled_valid),
    .out_raw_value    (out_raw_value),
    .out_raw_valid    (out_raw_valid),
    .out_floor_hit    (out_floor_hit),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .errors           (errors),
    .pending          (pending),
    .floor_hits       (floor_hits),
    .baseline         (baseline)
  );

  // Watchdog: a correct run needs a small fraction of this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Cycle limit of %0d reached with %0d results outstanding",
               CYCLE_LIMIT, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver back-pressure: random stall bursts, none once quiet.
  // Results come rarely, so the bursts land on every phase of the sequencer.
  always begin
    @(posedge clk);
    if (rst_n && !quiet && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    out_stall <= 1'b0;
  end

  // Write one register; hold the beat until cfg_ready, then drop valid for a cycle.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop the sample valid and wait until every expected result has been checked.
  // Each sample yields exactly one result, so the core is idle once none are pending.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write all seven registers; enable bits carry random upper bits that must be ignored.
  task automatic program_regs(input logic [DATA_W-1:0] c3, input logic [DATA_W-1:0] c2,
                              input logic [DATA_W-1:0] c1, input logic [DATA_W-1:0] off,
                              input logic [DATA_W-1:0] flo, input logic scaled_on,
                              input logic raw_on);
    cfg_write(REG_CUBIC, c3);
    cfg_write(REG_SQUARE, c2);
    cfg_write(REG_LINEAR, c1);
    cfg_write(REG_OFFSET, off);
    cfg_write(REG_FLOOR, flo);
    cfg_write(REG_SCALED, {31'($urandom()), scaled_on});
    cfg_write(REG_RAW, {31'($urandom()), raw_on});
    settings++;
  endtask

  // Send one sample beat; hold it while stalled, then maybe idle for a burst.
  task automatic send_sample(input logic [RAW_W-1:0] raw, input logic signed [VOLT_W-1:0] volts);
    in_valid      <= 1'b1;
    in_raw_sample <= raw;
    in_volts_in   <= volts;
    do @(posedge clk); while (in_stall);
    samples++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Coefficients: mostly moderate magnitudes so results stay in range, some full-width.
  function automatic logic [DATA_W-1:0] rand_coeff();
    int span;
    span = $urandom_range(4, 22);
    if ($urandom_range(0, 7) == 0) return $urandom();
    return DATA_W'(int'($urandom_range(0, 2 ** (span + 1))) - 2 ** span);
  endfunction

  function automatic logic signed [VOLT_W-1:0] rand_volts();
    case ($urandom_range(0, 5))
      0, 1:    return VOLT_W'($urandom());
      2:       return 16'sh8000;
      3:       return 16'sh7fff;
      default: return VOLT_W'(int'($urandom_range(0, 16384)) - 8192);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_floor();
    case ($urandom_range(0, 3))
      0:       return Q_MIN;
      1:       return $urandom();
      default: return DATA_W'(int'($urandom_range(0, 2 ** 20)) - 2 ** 19);
    endcase
  endfunction

  // Offset that cancels most of the accumulated baseline, plus a random term.
  // Without it a saturated baseline would pin every later result at the top.
  function automatic logic [DATA_W-1:0] offset_near(input logic signed [DATA_W-1:0] base);
    longint x;
    x = longint'($signed(rand_coeff())) - longint'(base);
    if (x > SAT_HI) x = SAT_HI;
    if (x < SAT_LO) x = SAT_LO;
    return x[DATA_W-1:0];
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: linear coefficient 65536 (gain 16), floor at the bottom, raw echo off.
    send_sample(16'h0000, 16'sh0000);
    send_sample(16'hffff, 16'sh7fff);
    send_sample(16'h0001, 16'sh8000);
    send_sample(16'haaaa, -16'sd1);
    send_sample(16'h5555, 16'sd1);
    send_sample(16'h8000, 16'sh1000);

    // Positive extremes: full-scale inputs saturate the sum; the lowest floor is never hit.
    // An out-of-range index goes first and must change nothing.
    drain_results();
    cfg_write(REG_UNUSED, '1);
    program_regs(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, 1'b1, 1'b1);
    send_sample(16'hffff, 16'sh7fff);
    send_sample(16'h0000, 16'sh8000);
    send_sample(16'h5555, 16'sh0000);

    // All negative extremes against a floor at zero: the shortfall saturates the
    // baseline, then the raised baseline shows up in the later results.
    drain_results();
    program_regs(Q_MIN, Q_MIN, Q_MIN, Q_MIN, '0, 1'b1, 1'b1);
    send_sample(16'h1234, 16'sh7fff);
    send_sample(16'hfedc, 16'sh8000);
    send_sample(16'h00ff, -16'sd1);

    // Scaled path off with raw echo on, then both off.
    drain_results();
    program_regs(Q_MIN, Q_MIN, Q_MIN, Q_MIN, '0, 1'b0, 1'b1);
    send_sample(16'hffff, 16'sh8000);
    send_sample(16'h0000, 16'sh7fff);
    drain_results();
    program_regs('0, '0, '0, '0, '0, 1'b0, 1'b0);
    send_sample(16'hc3c3, 16'sh4000);
    send_sample(16'h3c3c, -16'sd4096);

    // Floor at the top: every result clamps, the baseline stays saturated.
    drain_results();
    program_regs('0, '0, '0, '1, Q_MAX, 1'b1, 1'b0);
    send_sample(16'h0f0f, 16'sh0000);
    send_sample(16'hf0f0, 16'sh7fff);

    // Random phases: fresh settings each time, offset pulled back against the baseline.
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_results();
      if (p == RAND_PHASES - 1) quiet = 1'b1;
      program_regs(rand_coeff(), rand_coeff(), rand_coeff(), offset_near(baseline),
                   rand_floor(), $urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)));
      if (p % 4 == 1) cfg_write(REG_UNUSED, $urandom());
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        send_sample(RAW_W'($urandom()), rand_volts());
    end

    // Let late or spurious beats surface before the verdict.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d samples under %0d register settings, extremes then random.",
             samples, settings);
    $display("Floor clamps predicted: %0d, final baseline %0d.", floor_hits, baseline);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/cubcal_pkg.sv
src/cubcal_sermul.sv
src/cubcal_seq.sv
src/cubic_calibration_with_floor_baseline_core.sv
src/cubcal_chk.sv
tb/cubcal_checker.sv
tb/tb_cubic_calibration_with_floor_baseline_core.sv
